>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; they compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> hw/rtl/crcs_pkg.sv
// Types and constants for the CIGAR run coalescer and scorer.
package crcs_pkg;

    // Normalized traceback ops
    localparam logic [1:0] OP_M = 2'd0;
    localparam logic [1:0] OP_X = 2'd1;
    localparam logic [1:0] OP_D = 2'd2;
    localparam logic [1:0] OP_I = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_MATCH      = 2'd0;
    localparam logic [1:0] REG_MISMATCH   = 2'd1;
    localparam logic [1:0] REG_GAP_OPEN   = 2'd2;
    localparam logic [1:0] REG_GAP_EXTEND = 2'd3;

    // Score defaults after reset
    localparam logic [15:0] MATCH_RST      = 16'h0002;
    localparam logic [15:0] MISMATCH_RST   = 16'hFFFD;
    localparam logic [15:0] GAP_OPEN_RST   = 16'hFFFB;
    localparam logic [15:0] GAP_EXTEND_RST = 16'hFFFF;

    localparam int RUN_LEN_W = 17;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [1:0]           run_op;
        logic [RUN_LEN_W-1:0] run_len;
        logic                 last_run;
        logic                 empty_trace;
        logic [31:0]          score;
        logic [30:0]          q_beg;
        logic [31:0]          q_end;
        logic [30:0]          s_beg;
        logic [31:0]          s_end;
    } res_t;

endpackage

>>> hw/rtl/crcs_res_queue.sv
// Small result queue: takes up to two results per cycle, delivers one per cycle while rd_ready is high.
`include "assert_macros.svh"
module crcs_res_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        wr_num,
    input  crcs_pkg::res_t    wr_data0,
    input  crcs_pkg::res_t    wr_data1,
    output logic              room2,
    output logic              rd_valid,
    input  logic              rd_ready,
    output crcs_pkg::res_t    rd_data
);

    crcs_pkg::res_t                  mem_reg [crcs_pkg::Q_DEPTH];
    logic [crcs_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [crcs_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [crcs_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                            pop;

    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    // room for two more requests, not counting a pop this cycle
    assign room2    = (cnt_reg <= crcs_pkg::Q_CNT_W'(crcs_pkg::Q_DEPTH - 2));

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + crcs_pkg::Q_PTR_W'(wr_num);
        rd_ptr_next = rd_ptr_reg + crcs_pkg::Q_PTR_W'(pop);
        cnt_next    = cnt_reg + crcs_pkg::Q_CNT_W'(wr_num) - crcs_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage writes, second entry lands behind the first
    always_ff @(posedge aclk) begin
        if (wr_num != 2'd0) begin
            mem_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_num == 2'd2) begin
            mem_reg[wr_ptr_reg + crcs_pkg::Q_PTR_W'(1)] <= wr_data1;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, aclk, aresetn, (cnt_reg + crcs_pkg::Q_CNT_W'(wr_num)) <= crcs_pkg::Q_CNT_W'(crcs_pkg::Q_DEPTH), "result queue overflow")
    `ASSERT_NEXT(a_drain_empty, aclk, aresetn, pop && cnt_reg == crcs_pkg::Q_CNT_W'(1) && wr_num == 2'd0, !rd_valid, "queue not empty after last pop")
    `ASSERT_NEXT(a_double_push, aclk, aresetn, wr_num == 2'd2 && !pop, cnt_reg == $past(cnt_reg) + crcs_pkg::Q_CNT_W'(2), "double push lost an entry")

endmodule

>>> hw/rtl/cigar_run_coalesce_and_score.sv
// Path: a request is held in the input register, then written into the result queue, whose
// head drives the result port; the input register holds it while the queue lacks room.
// Throughput: one op per cycle while the queue holds two or fewer results; an op that both
// closes a run and ends the alignment yields two, drained at one per cycle while m_ready is high.
// Per-op score and span updates are incremental, one adder per accumulator, no multiplier.
// Reset: synchronous, active low; clears the open alignment and queue, restores default scores.
`include "assert_macros.svh"
module cigar_run_coalesce_and_score #(
    parameter int MAX_OPS = 65536
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    // op stream
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_op_code,
    input  logic               s_has_ops,
    input  logic               s_last,
    input  logic signed [31:0] s_q_beg_reported,
    input  logic signed [31:0] s_s_beg_reported,
    input  logic signed [31:0] s_q_end_reported,
    input  logic signed [31:0] s_s_end_reported,
    input  logic signed [31:0] s_score_reported,
    // run results
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_run_op,
    output logic [16:0]        m_run_len,
    output logic               m_last_run,
    output logic               m_empty_trace,
    output logic signed [31:0] m_align_score,
    output logic [30:0]        m_q_beg_out,
    output logic signed [31:0] m_q_end_out,
    output logic [30:0]        m_s_beg_out,
    output logic signed [31:0] m_s_end_out
);

    localparam int CNT_W = $clog2(MAX_OPS + 1);

    // score registers
    logic [15:0] match_reg, mismatch_reg, gap_open_reg, gap_extend_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_op_reg;
    logic        in_has_ops_reg, in_last_reg;
    logic [31:0] in_qb_reg, in_sb_reg, in_qe_reg, in_se_reg, in_score_reg;

    // alignment state
    logic             in_align_reg, in_align_next;
    logic [1:0]       cur_op_reg, cur_op_next;
    logic [CNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic [31:0]      q_span_reg, q_span_next;
    logic [31:0]      r_span_reg, r_span_next;
    logic [31:0]      acc_reg, acc_next;

    // datapath
    logic             advance, room2;
    logic [1:0]       op;
    logic             change, first, counted;
    logic [15:0]      step;
    logic [31:0]      delta;
    logic [CNT_W-1:0] cnt_new;
    logic [31:0]      q_span_new, r_span_new, acc_new;
    logic [30:0]      qb_c, sb_c, qe_c, se_c;
    logic [1:0]       wr_num;
    crcs_pkg::res_t   wr_data0, wr_data1, res_closed, res_final, res_empty, rd_data;

    assign advance = in_valid_reg && room2;
    assign s_ready = !in_valid_reg || room2;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg      <= crcs_pkg::MATCH_RST;
            mismatch_reg   <= crcs_pkg::MISMATCH_RST;
            gap_open_reg   <= crcs_pkg::GAP_OPEN_RST;
            gap_extend_reg <= crcs_pkg::GAP_EXTEND_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                crcs_pkg::REG_MATCH:      match_reg      <= cfg_wdata;
                crcs_pkg::REG_MISMATCH:   mismatch_reg   <= cfg_wdata;
                crcs_pkg::REG_GAP_OPEN:   gap_open_reg   <= cfg_wdata;
                crcs_pkg::REG_GAP_EXTEND: gap_extend_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg      <= s_op_code;
            in_has_ops_reg <= s_has_ops;
            in_last_reg    <= s_last;
            in_qb_reg      <= s_q_beg_reported;
            in_sb_reg      <= s_s_beg_reported;
            in_qe_reg      <= s_q_end_reported;
            in_se_reg      <= s_s_end_reported;
            in_score_reg   <= s_score_reported;
        end
    end

    // run tracking and incremental score
    always_comb begin
        op      = (in_op_reg[7:2] != '0) ? crcs_pkg::OP_M : in_op_reg[1:0];
        change  = in_align_reg && (op != cur_op_reg);
        first   = !in_align_reg || change;
        counted = first || (run_cnt_reg < CNT_W'(MAX_OPS));

        case (op)
            crcs_pkg::OP_M: step = match_reg;
            crcs_pkg::OP_X: step = mismatch_reg;
            default:        step = first ? gap_open_reg : gap_extend_reg;
        endcase
        delta = counted ? {{16{step[15]}}, step} : '0;

        if (first) begin
            cnt_new = CNT_W'(1);
        end else if (counted) begin
            cnt_new = run_cnt_reg + CNT_W'(1);
        end else begin
            cnt_new = run_cnt_reg;
        end
        q_span_new = q_span_reg + 32'(counted && (op != crcs_pkg::OP_D));
        r_span_new = r_span_reg + 32'(counted && (op != crcs_pkg::OP_I));
        acc_new    = acc_reg + delta;

        // negative coordinates clamp to zero
        qb_c = in_qb_reg[31] ? '0 : in_qb_reg[30:0];
        sb_c = in_sb_reg[31] ? '0 : in_sb_reg[30:0];
        qe_c = in_qe_reg[31] ? '0 : in_qe_reg[30:0];
        se_c = in_se_reg[31] ? '0 : in_se_reg[30:0];
    end

    // result assembly
    always_comb begin
        res_closed             = '0;
        res_closed.run_op      = cur_op_reg;
        res_closed.run_len     = crcs_pkg::RUN_LEN_W'(run_cnt_reg);

        res_final              = '0;
        res_final.run_op       = op;
        res_final.run_len      = crcs_pkg::RUN_LEN_W'(cnt_new);
        res_final.last_run     = 1'b1;
        res_final.score        = acc_new;
        res_final.q_beg        = qb_c;
        res_final.q_end        = {1'b0, qb_c} + q_span_new;
        res_final.s_beg        = sb_c;
        res_final.s_end        = {1'b0, sb_c} + r_span_new;

        res_empty              = '0;
        res_empty.last_run     = 1'b1;
        res_empty.empty_trace  = 1'b1;
        res_empty.score        = in_score_reg;
        res_empty.q_beg        = qb_c;
        res_empty.q_end        = {1'b0, (qe_c < qb_c) ? qb_c : qe_c};
        res_empty.s_beg        = sb_c;
        res_empty.s_end        = {1'b0, (se_c < sb_c) ? sb_c : se_c};

        wr_data1 = res_final;
        if (!in_has_ops_reg) begin
            wr_data0 = res_empty;
            wr_num   = 2'd1;
        end else begin
            wr_data0 = change ? res_closed : res_final;
            wr_num   = 2'(change) + 2'(in_last_reg);
        end
        if (!advance) begin
            wr_num = 2'd0;
        end
    end

    // alignment state next values
    always_comb begin
        in_align_next = in_align_reg;
        cur_op_next   = cur_op_reg;
        run_cnt_next  = run_cnt_reg;
        q_span_next   = q_span_reg;
        r_span_next   = r_span_reg;
        acc_next      = acc_reg;
        if (advance) begin
            if (!in_has_ops_reg || in_last_reg) begin
                in_align_next = 1'b0;
                cur_op_next   = crcs_pkg::OP_M;
                run_cnt_next  = '0;
                q_span_next   = '0;
                r_span_next   = '0;
                acc_next      = '0;
            end else begin
                in_align_next = 1'b1;
                cur_op_next   = op;
                run_cnt_next  = cnt_new;
                q_span_next   = q_span_new;
                r_span_next   = r_span_new;
                acc_next      = acc_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_align_reg <= 1'b0;
            cur_op_reg   <= crcs_pkg::OP_M;
            run_cnt_reg  <= '0;
            q_span_reg   <= '0;
            r_span_reg   <= '0;
            acc_reg      <= '0;
        end else begin
            in_align_reg <= in_align_next;
            cur_op_reg   <= cur_op_next;
            run_cnt_reg  <= run_cnt_next;
            q_span_reg   <= q_span_next;
            r_span_reg   <= r_span_next;
            acc_reg      <= acc_next;
        end
    end

    crcs_res_queue u_res_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_num   (wr_num),
        .wr_data0 (wr_data0),
        .wr_data1 (wr_data1),
        .room2    (room2),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_data  (rd_data)
    );

    assign m_run_op      = rd_data.run_op;
    assign m_run_len     = rd_data.run_len;
    assign m_last_run    = rd_data.last_run;
    assign m_empty_trace = rd_data.empty_trace;
    assign m_align_score = rd_data.score;
    assign m_q_beg_out   = rd_data.q_beg;
    assign m_q_end_out   = rd_data.q_end;
    assign m_s_beg_out   = rd_data.s_beg;
    assign m_s_end_out   = rd_data.s_end;

    `ASSERT_IMPLIES(a_idle_clear, aclk, aresetn, !in_align_reg, run_cnt_reg == '0 && q_span_reg == '0 && r_span_reg == '0 && acc_reg == '0, "closed alignment left state behind")
    `ASSERT_IMPLIES(a_open_nonzero, aclk, aresetn, in_align_reg, run_cnt_reg != '0, "open alignment with empty run")
    `ASSERT_ALWAYS(a_run_sat, aclk, aresetn, run_cnt_reg <= CNT_W'(MAX_OPS), "run length beyond saturation")
    `ASSERT_NEXT(a_end_closes, aclk, aresetn, advance && (!in_has_ops_reg || in_last_reg), !in_align_reg, "alignment still open after final op")

endmodule
